FILE: sv/slrm_pkg.sv
`default_nettype none

package slrm_pkg;

    localparam int MAX_LIST_DEF      = 30;
    localparam int TOTAL_SECTORS_DEF = 30;
    localparam int FIFO_DEPTH        = 4;

    typedef enum logic [1:0] {
        K_BEGIN = 2'd0,
        K_DATA  = 2'd1,
        K_FULL  = 2'd2
    } slrm_kind_t;

    typedef enum logic [1:0] {
        ST_RANGE = 2'd0,
        ST_ZERO  = 2'd1,
        ST_OVER  = 2'd2
    } slrm_status_t;

    typedef enum logic [2:0] {
        OP_CLR,
        OP_INS,
        OP_INS_LAST,
        OP_FULL,
        OP_ERR_ZERO,
        OP_ERR_OVER
    } slrm_op_t;

    typedef struct packed {
        slrm_op_t   op;
        logic [7:0] sector;
    } slrm_cmd_t;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_COUNT,
        PH_LIST
    } slrm_phase_t;

    typedef enum logic {
        B_IDLE,
        B_SCAN
    } slrm_bstate_t;

endpackage

`default_nettype wire

FILE: sv/sector_list_range_merger.sv
// channel   dir  tdata                         tuser        tlast
// s_        in   [7:0] data_byte               [1:0] kind   -
// m_        out  [7:0] range_first,            [1:0] status last
//                [15:8] range_last
//
// the front turns input transactions into queue commands; a short command queue
// feeds the back, which inserts each sector into a sorted row
// a finished list is scanned one entry per cycle, holding whenever a range is due
// but the result register is stalled
// aresetn is synchronous; no clearing pass is needed
// s_tready drops only while the command queue is full

`default_nettype none

module sector_list_range_merger
    import slrm_pkg::*;
#(
    parameter int MAX_LIST      = MAX_LIST_DEF,
    parameter int TOTAL_SECTORS = TOTAL_SECTORS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // data_byte
    input  wire logic [1:0]  s_tuser,   // kind
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // range_first, range_last
    output logic [1:0]       m_tuser,   // status
    output logic             m_tlast
);

    slrm_cmd_t    push_cmd, pop_cmd;
    logic         push, fifo_full, pop, cmd_avail;
    slrm_status_t out_status;
    logic [7:0]   out_first, out_lastsec;

    slrm_front #(
        .MAX_LIST (MAX_LIST)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_kind   (s_tuser),
        .in_byte   (s_tdata),
        .push      (push),
        .push_cmd  (push_cmd),
        .fifo_full (fifo_full)
    );

    slrm_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (fifo_full),
        .pop      (pop),
        .avail    (cmd_avail),
        .pop_cmd  (pop_cmd)
    );

    slrm_back #(
        .MAX_LIST      (MAX_LIST),
        .TOTAL_SECTORS (TOTAL_SECTORS)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd_avail   (cmd_avail),
        .cmd         (pop_cmd),
        .pop         (pop),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_status  (out_status),
        .out_first   (out_first),
        .out_lastsec (out_lastsec),
        .out_final   (m_tlast)
    );

    assign m_tdata = {out_lastsec, out_first};
    assign m_tuser = out_status;

endmodule

`default_nettype wire

FILE: sv/slrm_fifo.sv
`default_nettype none

module slrm_fifo
    import slrm_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      push,
    input  wire slrm_cmd_t push_cmd,
    output logic           full,
    input  wire logic      pop,
    output logic           avail,
    output slrm_cmd_t      pop_cmd
);

    localparam int AW = $clog2(FIFO_DEPTH);

    slrm_cmd_t        mem_reg [FIFO_DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [AW:0]      cnt_reg, cnt_next;
    logic             do_push, do_pop;

    assign full    = (cnt_reg == (AW+1)'(FIFO_DEPTH));
    assign avail   = (cnt_reg != '0);
    assign pop_cmd = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && avail;

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

FILE: sv/slrm_front.sv
`default_nettype none

module slrm_front
    import slrm_pkg::*;
#(
    parameter int MAX_LIST = MAX_LIST_DEF
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [1:0] in_kind,
    input  wire logic [7:0] in_byte,
    output logic            push,
    output slrm_cmd_t       push_cmd,
    input  wire logic       fifo_full
);

    localparam int CW = $clog2(MAX_LIST + 1);

    slrm_phase_t   phase_reg, phase_next;
    logic [CW-1:0] expected_reg, expected_next;
    logic [CW-1:0] fill_reg, fill_next;
    logic [CW-1:0] fill_inc;
    logic          take;

    assign in_ready = !fifo_full;
    assign take     = in_valid && in_ready;
    assign fill_inc = fill_reg + 1'b1;

    always_comb begin
        phase_next      = phase_reg;
        expected_next   = expected_reg;
        fill_next       = fill_reg;
        push            = 1'b0;
        push_cmd.op     = OP_INS;
        push_cmd.sector = in_byte;
        if (take) begin
            case (in_kind)
                K_BEGIN: begin
                    phase_next = PH_COUNT;
                    fill_next  = '0;
                end
                K_FULL: begin
                    phase_next  = PH_IDLE;
                    push        = 1'b1;
                    push_cmd.op = OP_FULL;
                end
                K_DATA: begin
                    case (phase_reg)
                        PH_COUNT: begin
                            push = 1'b1;
                            if (in_byte == 8'd0) begin
                                phase_next  = PH_IDLE;
                                push_cmd.op = OP_ERR_ZERO;
                            end else if (in_byte > 8'(MAX_LIST)) begin
                                phase_next  = PH_IDLE;
                                push_cmd.op = OP_ERR_OVER;
                            end else begin
                                phase_next    = PH_LIST;
                                expected_next = in_byte[CW-1:0];
                                fill_next     = '0;
                                push_cmd.op   = OP_CLR;
                            end
                        end
                        PH_LIST: begin
                            push      = 1'b1;
                            fill_next = fill_inc;
                            if (fill_inc >= expected_reg) begin
                                phase_next  = PH_IDLE;
                                push_cmd.op = OP_INS_LAST;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_IDLE;
            expected_reg <= '0;
            fill_reg     <= '0;
        end else begin
            phase_reg    <= phase_next;
            expected_reg <= expected_next;
            fill_reg     <= fill_next;
        end
    end

    a_fill_below_count: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_LIST |-> fill_reg < expected_reg && expected_reg != '0)
        else $error("fill index reached the expected count inside a list");

endmodule

`default_nettype wire

FILE: sv/slrm_back.sv
`default_nettype none

module slrm_back
    import slrm_pkg::*;
#(
    parameter int MAX_LIST      = MAX_LIST_DEF,
    parameter int TOTAL_SECTORS = TOTAL_SECTORS_DEF
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       cmd_avail,
    input  wire slrm_cmd_t  cmd,
    output logic            pop,
    output logic            out_valid,
    input  wire logic       out_ready,
    output slrm_status_t    out_status,
    output logic [7:0]      out_first,
    output logic [7:0]      out_lastsec,
    output logic            out_final
);

    localparam int CW = $clog2(MAX_LIST + 1);

    slrm_bstate_t  state_reg, state_next;
    logic [7:0]    list_reg [MAX_LIST];
    logic [7:0]    list_next [MAX_LIST];
    logic [7:0]    list_prev [MAX_LIST];
    logic [7:0]    list_ins [MAX_LIST];
    logic [MAX_LIST-1:0] gt, gt_prev;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [7:0]    run_first_reg, run_first_next;

    logic          oval_reg, oval_next;
    slrm_status_t  ostat_reg, ostat_next;
    logic [7:0]    ofirst_reg, ofirst_next;
    logic [7:0]    olast_reg, olast_next;
    logic          ofinal_reg, ofinal_next;

    logic          load_ok;
    logic          consec;

    assign load_ok     = !oval_reg || out_ready;
    assign out_valid   = oval_reg;
    assign out_status  = ostat_reg;
    assign out_first   = ofirst_reg;
    assign out_lastsec = olast_reg;
    assign out_final   = ofinal_reg;

    // sorted insert: every slot picks its left neighbor, the new value or itself
    always_comb begin
        for (int i = 0; i < MAX_LIST; i++) begin
            gt[i] = (CW'(i) < cnt_reg) && (list_reg[i] > cmd.sector);
        end
        gt_prev      = {gt[MAX_LIST-2:0], 1'b0};
        list_prev[0] = '0;
        for (int i = 1; i < MAX_LIST; i++) begin
            list_prev[i] = list_reg[i-1];
        end
        for (int i = 0; i < MAX_LIST; i++) begin
            if (gt_prev[i]) begin
                list_ins[i] = list_prev[i];
            end else if (gt[i] || CW'(i) == cnt_reg) begin
                list_ins[i] = cmd.sector;
            end else begin
                list_ins[i] = list_reg[i];
            end
        end
    end

    assign consec = (cnt_reg > CW'(1)) &&
                    ({1'b0, list_reg[1]} == {1'b0, list_reg[0]} + 9'd1);

    always_comb begin
        state_next     = state_reg;
        list_next      = list_reg;
        cnt_next       = cnt_reg;
        run_first_next = run_first_reg;
        pop            = 1'b0;
        oval_next      = oval_reg && !out_ready;
        ostat_next     = ostat_reg;
        ofirst_next    = ofirst_reg;
        olast_next     = olast_reg;
        ofinal_next    = ofinal_reg;
        case (state_reg)
            B_IDLE: begin
                if (cmd_avail) begin
                    case (cmd.op)
                        OP_CLR: begin
                            pop      = 1'b1;
                            cnt_next = '0;
                        end
                        OP_INS: begin
                            pop       = 1'b1;
                            list_next = list_ins;
                            cnt_next  = cnt_reg + 1'b1;
                        end
                        OP_INS_LAST: begin
                            pop            = 1'b1;
                            list_next      = list_ins;
                            cnt_next       = cnt_reg + 1'b1;
                            run_first_next = list_ins[0];
                            state_next     = B_SCAN;
                        end
                        OP_FULL, OP_ERR_ZERO, OP_ERR_OVER: begin
                            if (load_ok) begin
                                pop         = 1'b1;
                                oval_next   = 1'b1;
                                ofinal_next = 1'b1;
                                ofirst_next = '0;
                                olast_next  = '0;
                                ostat_next  = ST_RANGE;
                                if (cmd.op == OP_FULL) begin
                                    olast_next = 8'(TOTAL_SECTORS - 1);
                                end else if (cmd.op == OP_ERR_ZERO) begin
                                    ostat_next = ST_ZERO;
                                end else begin
                                    ostat_next = ST_OVER;
                                end
                            end
                        end
                        default: begin
                            pop = 1'b1;
                        end
                    endcase
                end
            end
            B_SCAN: begin
                if (consec || load_ok) begin
                    for (int i = 0; i < MAX_LIST - 1; i++) begin
                        list_next[i] = list_reg[i+1];
                    end
                    cnt_next = cnt_reg - 1'b1;
                end
                if (!consec && load_ok) begin
                    oval_next      = 1'b1;
                    ostat_next     = ST_RANGE;
                    ofirst_next    = run_first_reg;
                    olast_next     = list_reg[0];
                    ofinal_next    = (cnt_reg == CW'(1));
                    run_first_next = list_reg[1];
                    if (cnt_reg == CW'(1)) begin
                        state_next = B_IDLE;
                    end
                end
            end
            default: begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= B_IDLE;
            cnt_reg   <= '0;
            oval_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            oval_reg  <= oval_next;
        end
    end

    always_ff @(posedge aclk) begin
        list_reg      <= list_next;
        run_first_reg <= run_first_next;
        ostat_reg     <= ostat_next;
        ofirst_reg    <= ofirst_next;
        olast_reg     <= olast_next;
        ofinal_reg    <= ofinal_next;
    end

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CW'(MAX_LIST))
        else $error("list count beyond capacity");

    a_scan_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == B_SCAN |-> cnt_reg != '0)
        else $error("range scan with an empty list");

    a_error_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        oval_reg && ostat_reg != ST_RANGE |->
            ofirst_reg == '0 && olast_reg == '0 && ofinal_reg)
        else $error("error transaction with nonzero range or not final");

    a_scan_no_pop: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == B_SCAN |-> !pop)
        else $error("command taken during range scan");

endmodule

`default_nettype wire

FILE: tb/sv/tb_sector_list_range_merger.sv
`timescale 1ns / 100ps

module tb_sector_list_range_merger;
    import slrm_pkg::*;

    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam int STIM_TARGET  = 170;
    localparam int STALL_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 120;

    typedef struct {
        logic [1:0] kind;
        logic [7:0] data_byte;
    } erase_item_t;

    typedef struct packed {
        slrm_status_t status;
        logic [7:0]   first_sector;
        logic [7:0]   last_sector;
        logic         is_last;
    } range_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;     // data_byte
    logic [1:0]  s_tuser = '0;     // kind
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;          // range_first, range_last
    logic [1:0]  m_tuser;          // status
    logic        m_tlast;

    erase_item_t   pending_items[$];
    range_result_t expected_ranges[$];

    // predicted block state
    slrm_phase_t sess_phase = PH_IDLE;
    logic [4:0]  sess_count = '0;
    logic [4:0]  sess_fill = '0;
    logic [7:0]  sess_store [MAX_LIST_DEF];

    int  stim_items = 0;
    int  accepted_items = 0;
    int  results_checked = 0;
    int  lists_merged = 0;
    int  count_errors = 0;
    int  full_erases = 0;
    int  fail_count = 0;
    int  quiet_cycles = 0;
    int  src_wait = 0;
    int  snk_wait = 0;
    bit  src_quiet = 1'b0;
    bit  snk_quiet = 1'b0;

    sector_list_range_merger DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    function automatic int pause_len(input bit quiet);
        return quiet ? 0 : $urandom_range(0, 19);
    endfunction

    task automatic add(input logic [1:0] kind, input logic [7:0] data_byte, input bit ignored);
        erase_item_t it;
        it.kind = kind;
        it.data_byte = data_byte;
        pending_items.push_back(it);
        if (!ignored) begin
            stim_items++;
        end
    endtask

    // sector numbers clustered around a base so runs and duplicates show up
    task automatic add_sectors(input int n);
        logic [7:0] base;
        logic [7:0] sector;
        int         pick;
        case ($urandom_range(0, 3))
            0: base = 8'($urandom_range(250, 255));
            1: base = 8'($urandom_range(0, 3));
            default: base = 8'($urandom);
        endcase
        sector = base;
        for (int i = 0; i < n; i++) begin
            pick = $urandom_range(0, 9);
            if (pick < 6) begin
                sector = base + 8'($urandom_range(0, n + 1));
            end else if (pick < 8) begin
                sector = 8'($urandom);
            end
            if ($urandom_range(0, 9) == 0) begin
                add(KIND_UNUSED, 8'($urandom), 1'b1);
            end
            add(K_DATA, sector, 1'b0);
        end
    endtask

    task automatic predict_erase_item(input logic [1:0] kind, input logic [7:0] data_in);
        int         n;
        int         start;
        int         stop;
        logic [7:0] t;
        case (kind)
            K_BEGIN: begin
                sess_phase = PH_COUNT;
                sess_fill = '0;
            end
            K_FULL: begin
                sess_phase = PH_IDLE;
                expected_ranges.push_back('{ST_RANGE, 8'd0, 8'(TOTAL_SECTORS_DEF - 1), 1'b1});
                full_erases++;
            end
            K_DATA: begin
                if (sess_phase == PH_COUNT) begin
                    if (data_in == 8'd0) begin
                        sess_phase = PH_IDLE;
                        expected_ranges.push_back('{ST_ZERO, 8'd0, 8'd0, 1'b1});
                        count_errors++;
                    end else if (data_in > MAX_LIST_DEF) begin
                        sess_phase = PH_IDLE;
                        expected_ranges.push_back('{ST_OVER, 8'd0, 8'd0, 1'b1});
                        count_errors++;
                    end else begin
                        sess_count = data_in[4:0];
                        sess_fill = '0;
                        sess_phase = PH_LIST;
                    end
                end else if (sess_phase == PH_LIST) begin
                    sess_store[sess_fill] = data_in;
                    sess_fill++;
                    if (sess_fill >= sess_count) begin
                        sess_phase = PH_IDLE;
                        lists_merged++;
                        n = sess_count;
                        for (int i = 0; i + 1 < n; i++) begin
                            for (int j = i + 1; j < n; j++) begin
                                if (sess_store[i] > sess_store[j]) begin
                                    t = sess_store[i];
                                    sess_store[i] = sess_store[j];
                                    sess_store[j] = t;
                                end
                            end
                        end
                        // a repeated sector is not a successor, so it opens a new run
                        start = 0;
                        while (start < n) begin
                            stop = start;
                            while (stop + 1 < n && {1'b0, sess_store[stop + 1]} ==
                                   {1'b0, sess_store[stop]} + 9'd1) begin
                                stop++;
                            end
                            expected_ranges.push_back('{ST_RANGE, sess_store[start],
                                sess_store[stop], (stop + 1 >= n)});
                            start = stop + 1;
                        end
                    end
                end
            end
            default: ;
        endcase
    endtask

    // source side: one transaction per item, random gap after each
    always @(posedge aclk) begin : src_drive
        erase_item_t nxt;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            src_wait <= 0;
        end else begin
            if (s_tvalid && s_tready) begin
                predict_erase_item(s_tuser, s_tdata);
                accepted_items++;
            end
            if (!s_tvalid || s_tready) begin
                if (src_wait != 0) begin
                    src_wait <= src_wait - 1;
                    s_tvalid <= 1'b0;
                end else if (pending_items.size() != 0) begin
                    nxt = pending_items.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser <= nxt.kind;
                    s_tdata <= nxt.data_byte;
                    if ($urandom_range(0, 15) == 0) begin
                        src_quiet = !src_quiet;
                    end
                    src_wait <= pause_len(src_quiet);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // sink side: stall each result a random number of cycles, then check it
    always @(posedge aclk) begin : snk_check
        range_result_t exp;
        int            next_wait;
        if (!aresetn) begin
            m_tready <= 1'b0;
            snk_wait <= 0;
        end else begin
            next_wait = snk_wait;
            if (m_tvalid && m_tready) begin
                results_checked++;
                if (expected_ranges.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10) begin
                        $display("%0t: result with none expected: status %0d range %0d..%0d last %0b",
                                 $realtime, m_tuser, m_tdata[7:0], m_tdata[15:8], m_tlast);
                    end
                end else begin
                    exp = expected_ranges.pop_front();
                    if (m_tuser !== exp.status || m_tdata[7:0] !== exp.first_sector ||
                        m_tdata[15:8] !== exp.last_sector || m_tlast !== exp.is_last) begin
                        fail_count++;
                        if (fail_count <= 10) begin
                            $display("%0t: mismatch: exp status %0d range %0d..%0d last %0b",
                                     $realtime, exp.status, exp.first_sector, exp.last_sector,
                                     exp.is_last);
                            $display("%0t:           got status %0d range %0d..%0d last %0b",
                                     $realtime, m_tuser, m_tdata[7:0], m_tdata[15:8], m_tlast);
                        end
                    end
                end
                if ($urandom_range(0, 15) == 0) begin
                    snk_quiet = !snk_quiet;
                end
                next_wait = pause_len(snk_quiet);
            end else if (m_tvalid && next_wait != 0) begin
                next_wait = next_wait - 1;
            end
            snk_wait <= next_wait;
            m_tready <= (next_wait == 0);
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge aclk);
        end
        $display("%0t: no transaction for %0d cycles", $realtime, STALL_LIMIT);
        $display("[sector_list_range_merger] ERROR");
        $finish;
    end

    initial begin
        int choice;
        int n;

        // directed: ignored items, full erase, count errors, sorting, duplicates,
        // sector 0 and 255, restart and full erase inside an open session
        add(K_DATA, 8'hFF, 1'b1);
        add(KIND_UNUSED, 8'hAA, 1'b1);
        add(K_FULL, 8'h55, 1'b0);
        add(K_BEGIN, 8'h00, 1'b0);
        add(K_DATA, 8'd0, 1'b0);
        add(K_BEGIN, 8'hFF, 1'b0);
        add(K_DATA, 8'd31, 1'b0);
        add(K_BEGIN, 8'h00, 1'b0);
        add(K_DATA, 8'd255, 1'b0);
        add(K_BEGIN, 8'h00, 1'b0);
        add(K_DATA, 8'd4, 1'b0);
        add(K_DATA, 8'd5, 1'b0);
        add(K_DATA, 8'd3, 1'b0);
        add(K_DATA, 8'd4, 1'b0);
        add(K_DATA, 8'd3, 1'b0);
        add(K_BEGIN, 8'h00, 1'b0);
        add(K_DATA, 8'd3, 1'b0);
        add(K_DATA, 8'd7, 1'b0);
        add(K_BEGIN, 8'h00, 1'b0);
        add(K_DATA, 8'd3, 1'b0);
        add(K_DATA, 8'd255, 1'b0);
        add(K_DATA, 8'd0, 1'b0);
        add(K_DATA, 8'd254, 1'b0);
        add(K_BEGIN, 8'h00, 1'b0);
        add(K_DATA, 8'd2, 1'b0);
        add(K_DATA, 8'd9, 1'b0);
        add(K_FULL, 8'h00, 1'b0);

        while (stim_items < STIM_TARGET) begin
            choice = $urandom_range(0, 99);
            if (choice < 68) begin
                case ($urandom_range(0, 19)) inside
                    [0:14]: n = $urandom_range(1, 8);
                    [15:18]: n = $urandom_range(9, 29);
                    default: n = MAX_LIST_DEF;
                endcase
                add(K_BEGIN, 8'($urandom), 1'b0);
                add(K_DATA, 8'(n), 1'b0);
                add_sectors(n);
            end else if (choice < 76) begin
                add(K_BEGIN, 8'($urandom), 1'b0);
                add(K_DATA, ($urandom_range(0, 2) == 0) ? 8'd0 : 8'($urandom_range(31, 255)),
                    1'b0);
            end else if (choice < 82) begin
                add(K_FULL, 8'($urandom), 1'b0);
            end else if (choice < 92) begin
                // list cut short by a full erase or by a new session
                n = $urandom_range(2, 10);
                add(K_BEGIN, 8'($urandom), 1'b0);
                add(K_DATA, 8'(n), 1'b0);
                add_sectors($urandom_range(1, n - 1));
                if ($urandom_range(0, 1) == 0) begin
                    add(K_FULL, 8'($urandom), 1'b0);
                end else begin
                    add(K_BEGIN, 8'($urandom), 1'b0);
                    add(K_DATA, 8'(n), 1'b0);
                    add_sectors(n);
                end
            end else if ($urandom_range(0, 1) == 0) begin
                add(KIND_UNUSED, 8'($urandom), 1'b1);
            end else begin
                add(K_DATA, 8'($urandom), 1'b1);
            end
        end

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_items.size() != 0 || s_tvalid) begin
            @(posedge aclk);
        end
        while (expected_ranges.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (expected_ranges.size() != 0) begin
            fail_count++;
            $display("%0d expected results never arrived", expected_ranges.size());
        end

        $display("input transactions %0d, results checked %0d", accepted_items, results_checked);
        $display("sector lists merged %0d, count rejects %0d, full erases %0d",
                 lists_merged, count_errors, full_erases);
        if (fail_count == 0) begin
            $display("[sector_list_range_merger] OK");
        end else begin
            $display("[sector_list_range_merger] ERROR");
        end
        $finish;
    end

endmodule

FILE: files.f
sv/slrm_pkg.sv
sv/slrm_fifo.sv
sv/slrm_front.sv
sv/slrm_back.sv
sv/sector_list_range_merger.sv
tb/sv/tb_sector_list_range_merger.sv
